[sv/grz4_pkg.sv]
package grz4_pkg;

  localparam int unsigned DEGREE    = 32;
  localparam int unsigned OPW       = 32;
  localparam int unsigned COEFS     = 2 * OPW;
  localparam int unsigned MUL_CELLS = OPW;
  localparam int unsigned RED_CELLS = COEFS - DEGREE;
  localparam int unsigned LATENCY   = MUL_CELLS + RED_CELLS;

  // bit-sliced Z4 polynomials: coefficient i = 2*hi[i] + lo[i]
  typedef struct packed {
    logic [COEFS-1:0] a_hi;
    logic [COEFS-1:0] a_lo;
    logic [OPW-1:0]   b_hi;
    logic [OPW-1:0]   b_lo;
    logic [COEFS-1:0] acc_hi;
    logic [COEFS-1:0] acc_lo;
  } mul_data_t;

  typedef struct packed {
    logic [COEFS-1:0] hi;
    logic [COEFS-1:0] lo;
  } red_data_t;

endpackage

[sv/grz4_mul_cell.sv]
module grz4_mul_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  grz4_pkg::mul_data_t   data_i,
  output logic                  valid_o,
  output grz4_pkg::mul_data_t   data_o
);
  import grz4_pkg::*;

  logic             valid_q;
  mul_data_t        data_d, data_q;
  logic [COEFS-1:0] term_hi, term_lo;

  // a * b[0] over Z4, accumulated with the lo carry into hi; a shifts up, b down
  always_comb begin
    term_hi = (data_i.a_hi & {COEFS{data_i.b_lo[0]}})
            ^ (data_i.a_lo & {COEFS{data_i.b_hi[0]}});
    term_lo = data_i.a_lo & {COEFS{data_i.b_lo[0]}};
    data_d.a_hi   = data_i.a_hi << 1;
    data_d.a_lo   = data_i.a_lo << 1;
    data_d.b_hi   = data_i.b_hi >> 1;
    data_d.b_lo   = data_i.b_lo >> 1;
    data_d.acc_hi = data_i.acc_hi ^ term_hi ^ (data_i.acc_lo & term_lo);
    data_d.acc_lo = data_i.acc_lo ^ term_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/grz4_red_cell.sv]
module grz4_red_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [grz4_pkg::COEFS-1:0]    mvec_i,
  input  logic                          valid_i,
  input  grz4_pkg::red_data_t           data_i,
  output logic                          valid_o,
  output grz4_pkg::red_data_t           data_o
);
  import grz4_pkg::*;

  logic             valid_q;
  red_data_t        data_d, data_q;
  logic             top_hi, top_lo;
  logic [COEFS-1:0] neg_hi, neg_lo, sum_hi, sum_lo;

  // subtract top coefficient times the aligned modulus, then shift up
  always_comb begin
    top_hi = data_i.hi[COEFS-1];
    top_lo = data_i.lo[COEFS-1];
    neg_lo = mvec_i & {COEFS{top_lo}};
    neg_hi = (mvec_i & {COEFS{top_hi}}) ^ neg_lo;
    sum_hi = data_i.hi ^ neg_hi ^ (data_i.lo & neg_lo);
    sum_lo = data_i.lo ^ neg_lo;
    data_d.hi = sum_hi << 1;
    data_d.lo = sum_lo << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/galois_ring_z4_multiply_reduce.sv]
// GR(4^n) multiplier, n = DEGREE, operands and result as hi/lo bit planes.
// Input: start_i with left_high_i/left_low_i/right_high_i/right_low_i; a
//   transfer happens on each edge where start_i is high and busy_o low.
//   busy_o is always low: a new operand pair may be given every cycle.
// Output: done_o marks product_high_o/product_low_o for exactly one cycle;
//   there is no back-pressure, the receiver must take each result.
// Config: cfg_we_i writes cfg_wdata_i into the modulus low part (bit i is
//   coefficient i, the x^n term is implicit). Write only while idle.
// Pipeline: a start transfer passes through the MUL_CELLS multiply cells and
//   then the RED_CELLS reduction cells to done_o. Throughput one per cycle.
// The cell chain has one cell per coefficient of the right operand for the
//   product, one per coefficient at or above DEGREE for the reduction.
// Reset clears all valid flags and the modulus register (modulus x^n);
//   items in flight are dropped.
module galois_ring_z4_multiply_reduce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] left_high_i,
  input  logic [31:0] left_low_i,
  input  logic [31:0] right_high_i,
  input  logic [31:0] right_low_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] product_high_o,
  output logic [31:0] product_low_o
);
  import grz4_pkg::*;

  logic [31:0]      modulus_q;
  logic [DEGREE:0]  mod_full;
  logic [COEFS-1:0] mvec;

  logic      mul_v    [MUL_CELLS+1];
  mul_data_t mul_data [MUL_CELLS+1];
  logic      red_v    [RED_CELLS+1];
  red_data_t red_data [RED_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '0;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // modulus aligned so that its x^n term sits on the top coefficient
  assign mod_full = {1'b1, modulus_q[DEGREE-1:0]};
  assign mvec     = COEFS'(mod_full) << (COEFS - 1 - DEGREE);

  assign busy_o = 1'b0;

  always_comb begin
    mul_v[0]           = start_i && !busy_o;
    mul_data[0].a_hi   = COEFS'(left_high_i);
    mul_data[0].a_lo   = COEFS'(left_low_i);
    mul_data[0].b_hi   = OPW'(right_high_i);
    mul_data[0].b_lo   = OPW'(right_low_i);
    mul_data[0].acc_hi = '0;
    mul_data[0].acc_lo = '0;
  end

  for (genvar k = 0; k < MUL_CELLS; k++) begin : g_mul
    grz4_mul_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mul_v[k]),
      .data_i  (mul_data[k]),
      .valid_o (mul_v[k+1]),
      .data_o  (mul_data[k+1])
    );
  end

  assign red_v[0]       = mul_v[MUL_CELLS];
  assign red_data[0].hi = mul_data[MUL_CELLS].acc_hi;
  assign red_data[0].lo = mul_data[MUL_CELLS].acc_lo;

  for (genvar k = 0; k < RED_CELLS; k++) begin : g_red
    grz4_red_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mvec_i  (mvec),
      .valid_i (red_v[k]),
      .data_i  (red_data[k]),
      .valid_o (red_v[k+1]),
      .data_o  (red_data[k+1])
    );
  end

  // after RED_CELLS shifts the remainder occupies the top DEGREE coefficients
  assign done_o         = red_v[RED_CELLS];
  assign product_high_o = 32'(red_data[RED_CELLS].hi[COEFS-1 -: DEGREE]);
  assign product_low_o  = 32'(red_data[RED_CELLS].lo[COEFS-1 -: DEGREE]);

`ifndef SYNTH
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without matching start transfer");

  a_start_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> mul_v[1])
    else $error("start transfer did not enter the chain");

  a_mul_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_v[MUL_CELLS] |-> (mul_data[MUL_CELLS].b_hi == '0 &&
                          mul_data[MUL_CELLS].b_lo == '0))
    else $error("right operand not fully consumed");

  a_red_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_data[RED_CELLS].hi[RED_CELLS-1:0] == '0 &&
                red_data[RED_CELLS].lo[RED_CELLS-1:0] == '0))
    else $error("reduction left nonzero shifted-in coefficients");
`endif

endmodule

[tb/galois_ring_z4_multiply_reduce_tb.sv]
`timescale 1ns / 1ps

module galois_ring_z4_multiply_reduce_tb;
  import grz4_pkg::*;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
  } z4_elem_t;

  typedef struct packed {
    z4_elem_t left;
    z4_elem_t right;
    bit       typed;
    z4_elem_t product;
  } stim_row_t;

  localparam int NUM_DIRECTED = 16;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 215;

  // operands as {hi, lo}; typed products assume the reset modulus x^32
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{32'h0, 32'h0}, '{32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0}},
    '{'{32'h0, 32'h1}, '{32'h0, 32'h1}, 1'b1, '{32'h0, 32'h1}},
    '{'{32'h1, 32'h1}, '{32'h1, 32'h1}, 1'b1, '{32'h0, 32'h1}},
    '{'{32'h1, 32'h0}, '{32'h1, 32'h0}, 1'b1, '{32'h0, 32'h0}},
    '{'{32'h1, 32'h0}, '{32'h1, 32'h1}, 1'b1, '{32'h1, 32'h0}},
    '{'{32'h0, 32'h1}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{'{32'h0, 32'h8000_0000}, '{32'h0, 32'h2}, 1'b1, '{32'h0, 32'h0}},
    '{'{32'h0, 32'h2}, '{32'h0, 32'h2}, 1'b1, '{32'h0, 32'h4}},
    '{'{32'h8000_0000, 32'h8000_0000}, '{32'h8000_0000, 32'h8000_0000}, 1'b1,
      '{32'h0, 32'h0}},
    '{'{32'hFFFF_FFFF, 32'h0}, '{32'hFFFF_FFFF, 32'h0}, 1'b1, '{32'h0, 32'h0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0,
      '{32'h0, 32'h0}},
    '{'{32'hAAAA_AAAA, 32'h5555_5555}, '{32'h5555_5555, 32'hAAAA_AAAA}, 1'b0,
      '{32'h0, 32'h0}},
    '{'{32'h0, 32'hFFFF_FFFF}, '{32'h0, 32'hFFFF_FFFF}, 1'b0, '{32'h0, 32'h0}},
    '{'{32'h1234_5678, 32'h9ABC_DEF0}, '{32'h0FED_CBA9, 32'h8765_4321}, 1'b0,
      '{32'h0, 32'h0}},
    '{'{32'h0, 32'hFFFF_FFFF}, '{32'h0, 32'h8000_0000}, 1'b0, '{32'h0, 32'h0}}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic        busy_o;
  logic [31:0] left_high_i    = '0;
  logic [31:0] left_low_i     = '0;
  logic [31:0] right_high_i   = '0;
  logic [31:0] right_low_i    = '0;
  logic        cfg_we_i       = 1'b0;
  logic [31:0] cfg_wdata_i    = '0;
  logic        done_o;
  logic [31:0] product_high_o;
  logic [31:0] product_low_o;

  z4_elem_t    expected_products [$];
  logic [31:0] modulus_shadow = '0;
  int          mismatch_count = 0;
  int          products_checked = 0;
  int          items_sent = 0;
  int          idle_pct = 11;

  galois_ring_z4_multiply_reduce i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .left_high_i    (left_high_i),
    .left_low_i     (left_low_i),
    .right_high_i   (right_high_i),
    .right_low_i    (right_low_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .product_high_o (product_high_o),
    .product_low_o  (product_low_o)
  );

  always #5 clk_i = ~clk_i;

  // product over Z4, reduced by x^DEGREE + modulus low part
  function automatic z4_elem_t z4_ring_product(input z4_elem_t a, input z4_elem_t b,
                                               input logic [31:0] modl);
    logic [1:0] acc [COEFS];
    logic [1:0] m [DEGREE+1];
    logic [1:0] ca, cb, c;
    z4_elem_t   res;
    for (int k = 0; k < COEFS; k++) acc[k] = 2'd0;
    for (int k = 0; k < DEGREE; k++) m[k] = {1'b0, modl[k]};
    m[DEGREE] = 2'd1;
    for (int i = 0; i < OPW; i++) begin
      ca = {a.hi[i], a.lo[i]};
      for (int j = 0; j < OPW; j++) begin
        cb = {b.hi[j], b.lo[j]};
        acc[i+j] = acc[i+j] + ca * cb;
      end
    end
    for (int d = COEFS - 1; d >= DEGREE; d--) begin
      c = acc[d];
      if (c != 2'd0) begin
        for (int i = 0; i <= DEGREE; i++) begin
          acc[d-DEGREE+i] = acc[d-DEGREE+i] - c * m[i];
        end
      end
    end
    res = '0;
    for (int k = 0; k < DEGREE; k++) begin
      res.hi[k] = acc[k][1];
      res.lo[k] = acc[k][0];
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_plane();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_operands(input z4_elem_t a, input z4_elem_t b, input bit typed,
                               input z4_elem_t product);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    left_high_i  <= a.hi;
    left_low_i   <= a.lo;
    right_high_i <= b.hi;
    right_low_i  <= b.lo;
    do @(posedge clk_i); while (busy_o);
    expected_products.insert(expected_products.size(),
                             typed ? product : z4_ring_product(a, b, modulus_shadow));
    items_sent++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    modulus_shadow = value;
  endtask

  always @(posedge clk_i) begin : check_products
    z4_elem_t want;
    if (rst_ni && done_o) begin
      if (expected_products.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: unexpected product hi=%h lo=%h", $time, product_high_o,
                   product_low_o);
        end
        mismatch_count++;
      end else begin
        want = expected_products.pop_front();
        products_checked++;
        if (product_high_o !== want.hi || product_low_o !== want.lo) begin
          if (mismatch_count < 10) begin
            $display("%0t: product mismatch: expected hi=%h lo=%h, got hi=%h lo=%h",
                     $time, want.hi, want.lo, product_high_o, product_low_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [31:0] moduli [NUM_PHASES];
    z4_elem_t    a, b;
    moduli = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, $urandom, 32'h0, $urandom};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset modulus is x^DEGREE
    foreach (DIRECTED_ROWS[r]) begin
      send_operands(DIRECTED_ROWS[r].left, DIRECTED_ROWS[r].right, DIRECTED_ROWS[r].typed,
                    DIRECTED_ROWS[r].product);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_modulus(moduli[p]);
      idle_pct = (p == 1) ? 0 : 11;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        a = '{rand_plane(), rand_plane()};
        b = '{rand_plane(), rand_plane()};
        send_operands(a, b, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("sent %0d operand pairs under %0d modulus settings, %0d products compared",
             items_sent, NUM_PHASES + 1, products_checked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad products", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for products");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
